[design/assert_macros.svh]
// Assertion macros shared by the RTL of the cosine similarity engine.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising edge outside reset.
`define CSIM_ASSERT(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Property that must never hold outside reset.
`define CSIM_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[design/csim_pkg.sv]
// Package of the cosine similarity engine: widths, defaults and the sequencer states.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
package csim_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SIM_W       = 16;
  localparam int ACC_W       = 42;
  localparam int ROOT_W      = ACC_W / 2;
  localparam int MUL_W       = ROOT_W + 1;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int Q_W         = 17;
  localparam int DEF_MAX_LEN = 1024;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAB,
    S_MAA,
    S_MBB,
    S_ACC,
    S_SQA,
    S_WA,
    S_WB,
    S_MULD,
    S_CHK,
    S_WD,
    S_OUT
  } state_t;

endpackage

[design/csim_if.sv]
// Valid/ready channel interfaces for the element pair and the similarity result.
// Depends on csim_pkg for the field widths.
interface csim_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [csim_pkg::SAMPLE_W-1:0]  elem_a;
  logic signed [csim_pkg::SAMPLE_W-1:0]  elem_b;
  logic                                  last;
  modport source (output valid, elem_a, elem_b, last, input ready);
  modport sink   (input valid, elem_a, elem_b, last, output ready);
endinterface

interface csim_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [csim_pkg::SIM_W-1:0]  similarity;
  logic                               zero_norm;
  logic                               overflow;
  modport source (output valid, similarity, zero_norm, overflow, input ready);
  modport sink   (input valid, similarity, zero_norm, overflow, output ready);
endinterface

[design/csim_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on csim_pkg for operand and product widths.
module csim_mul (
  input  logic                                clk,
  input  logic signed [csim_pkg::MUL_W-1:0]   op_a,
  input  logic signed [csim_pkg::MUL_W-1:0]   op_b,
  output logic signed [csim_pkg::PROD_W-1:0]  prod
);

  logic signed [csim_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

[design/csim_sqrt.sv]
// Iterative floor square root, one result bit per cycle.
// Depends on csim_pkg for the accumulator and root widths.
module csim_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [csim_pkg::ACC_W-1:0]         x,
  output logic                               done,
  output logic [csim_pkg::ROOT_W-1:0]        root
);

  localparam int CW = $clog2(csim_pkg::ROOT_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [csim_pkg::ACC_W-1:0]    x_r;
  logic [csim_pkg::ROOT_W+1:0]   rem_r;
  logic [csim_pkg::ROOT_W-1:0]   root_r;
  logic [csim_pkg::ROOT_W+1:0]   cur;
  logic [csim_pkg::ROOT_W+1:0]   trial;

  assign cur   = {rem_r[csim_pkg::ROOT_W-1:0], x_r[csim_pkg::ACC_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CW'(csim_pkg::ROOT_W - 1);
    end else if (busy_r) begin
      x_r   <= {x_r[csim_pkg::ACC_W-3:0], 2'b00};
      cnt_r <= cnt_r - 1'b1;
      if (cur >= trial) begin
        rem_r  <= cur - trial;
        root_r <= {root_r[csim_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= cur;
        root_r <= {root_r[csim_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[design/csim_div.sv]
// Iterative restoring divider producing a short quotient, one bit per cycle.
// Depends on csim_pkg; the caller guarantees the quotient fits in Q_W bits.
module csim_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [csim_pkg::ACC_W-1:0]    rem0,
  input  logic [1:0]                    lo,
  input  logic [csim_pkg::ACC_W-1:0]    divisor,
  output logic                          done,
  output logic [csim_pkg::Q_W-1:0]      quot
);

  localparam int CW = $clog2(csim_pkg::Q_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [csim_pkg::ACC_W-1:0]    rem_r;
  logic [csim_pkg::ACC_W-1:0]    d_r;
  logic [csim_pkg::Q_W-1:0]      lo_r;
  logic [csim_pkg::Q_W-1:0]      q_r;
  logic [csim_pkg::ACC_W:0]      cur;

  assign cur = {rem_r, lo_r[csim_pkg::Q_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      d_r   <= divisor;
      lo_r  <= {lo, {(csim_pkg::Q_W-2){1'b0}}};
      q_r   <= '0;
      cnt_r <= CW'(csim_pkg::Q_W - 1);
    end else if (busy_r) begin
      lo_r  <= {lo_r[csim_pkg::Q_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
      if (cur >= {1'b0, d_r}) begin
        rem_r <= csim_pkg::ACC_W'(cur - {1'b0, d_r});
        q_r   <= {q_r[csim_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_r <= cur[csim_pkg::ACC_W-1:0];
        q_r   <= {q_r[csim_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[design/cosine_similarity_engine.sv]
// Top level of the cosine similarity engine: sequencer, accumulators and result register.
// Depends on csim_pkg, csim_if, csim_mul, csim_sqrt, csim_div and assert_macros.svh.
//
// The engine takes one element pair (Q1.15) per input item and accumulates the dot
// product and both squared norms in 42-bit registers through a single shared 22x22
// multiplier. For an ordinary pair the multiplier is used three times in a row, and
// ready is high only in the idle state. The item marked last then runs the final
// phase: two floor square roots on one shared root unit (21 digit steps each), a
// product of the roots on the same multiplier, a saturation check, and a divider (17
// quotient bits), followed by the hand-off to the result register. The result item
// carries the similarity saturated to Q1.15; zero_norm is set with a zero similarity
// when either root is zero, and overflow with a zero similarity when more than
// MAX_LEN pairs arrived (pairs beyond MAX_LEN are dropped, and overflow wins over
// zero_norm). Pairs after the limit are taken in the idle state and skip the
// multiplier.
// The result sits in an output register, so the next vector may stream in while it
// waits to be taken. All accumulators clear when the result is handed over.
`include "assert_macros.svh"

module cosine_similarity_engine #(
  parameter int MAX_LEN = csim_pkg::DEF_MAX_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  csim_in_if.sink           in_ch,
  csim_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int ACC_W = csim_pkg::ACC_W;
  localparam int MUL_W = csim_pkg::MUL_W;
  localparam int ROOT_W = csim_pkg::ROOT_W;

  csim_pkg::state_t state_r, state_nxt;

  logic signed [csim_pkg::SAMPLE_W-1:0] a_r, b_r;
  logic                                  last_r;
  logic [ACC_W-1:0]                      dot_r, na_r, nb_r;
  logic [CNT_W-1:0]                      cnt_r;
  logic                                  too_long_r;
  logic [ROOT_W-1:0]                     ra_r;
  logic [ACC_W-1:0]                      mag_r;
  logic                                  neg_r;
  logic signed [csim_pkg::SIM_W-1:0]     pend_sim_r;
  logic                                  pend_z_r, pend_o_r;

  logic                                  out_valid_r;
  logic signed [csim_pkg::SIM_W-1:0]     out_sim_r;
  logic                                  out_z_r, out_o_r;

  logic signed [MUL_W-1:0]               op_a, op_b;
  logic signed [csim_pkg::PROD_W-1:0]    prod;
  logic                                  sq_start, sq_done;
  logic [ACC_W-1:0]                      sq_x;
  logic [ROOT_W-1:0]                     sq_root;
  logic                                  dv_start, dv_done;
  logic [csim_pkg::Q_W-1:0]              dv_quot;

  logic                                  accept;
  logic                                  drop;
  logic                                  out_free;
  logic [ACC_W-1:0]                      dot_mag;
  logic [ACC_W-1:0]                      divisor;
  logic                                  sat;
  logic signed [csim_pkg::SIM_W-1:0]     sat_sim;
  logic signed [csim_pkg::SIM_W-1:0]     div_sim;

  assign accept   = in_ch.valid && in_ch.ready;
  assign drop     = too_long_r || (cnt_r == CNT_W'(MAX_LEN));
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == csim_pkg::S_IDLE);

  // Magnitude of the dot product read as a 42-bit two's complement value.
  assign dot_mag = dot_r[ACC_W-1] ? (~dot_r + 1'b1) : dot_r;
  assign divisor = prod[ACC_W-1:0];
  // Quotient of at least 2^17 saturates either way, so the divider never sees it.
  assign sat     = {2'b00, mag_r} >= {divisor, 2'b00};
  assign sat_sim = neg_r ? csim_pkg::SIM_W'(16'h8000) : csim_pkg::SIM_W'(16'h7FFF);

  always_comb begin
    if (neg_r) begin
      if (dv_quot > csim_pkg::Q_W'(32768)) div_sim = csim_pkg::SIM_W'(16'h8000);
      else                                 div_sim = csim_pkg::SIM_W'(-dv_quot);
    end else begin
      if (dv_quot > csim_pkg::Q_W'(32767)) div_sim = csim_pkg::SIM_W'(16'h7FFF);
      else                                 div_sim = dv_quot[csim_pkg::SIM_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_r)
      csim_pkg::S_MAB: begin
        op_a = MUL_W'(a_r);
        op_b = MUL_W'(b_r);
      end
      csim_pkg::S_MAA: begin
        op_a = MUL_W'(a_r);
        op_b = MUL_W'(a_r);
      end
      csim_pkg::S_MBB: begin
        op_a = MUL_W'(b_r);
        op_b = MUL_W'(b_r);
      end
      csim_pkg::S_MULD: begin
        op_a = {1'b0, ra_r};
        op_b = {1'b0, sq_root};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Sequencer next state and unit start strobes.
  always_comb begin
    state_nxt = state_r;
    sq_start  = 1'b0;
    sq_x      = na_r;
    dv_start  = 1'b0;
    case (state_r)
      csim_pkg::S_IDLE: begin
        if (accept) begin
          if (!drop)             state_nxt = csim_pkg::S_MAB;
          else if (in_ch.last)   state_nxt = csim_pkg::S_OUT;
        end
      end
      csim_pkg::S_MAB: state_nxt = csim_pkg::S_MAA;
      csim_pkg::S_MAA: state_nxt = csim_pkg::S_MBB;
      csim_pkg::S_MBB: state_nxt = csim_pkg::S_ACC;
      csim_pkg::S_ACC: state_nxt = last_r ? csim_pkg::S_SQA : csim_pkg::S_IDLE;
      csim_pkg::S_SQA: begin
        sq_start  = 1'b1;
        state_nxt = csim_pkg::S_WA;
      end
      csim_pkg::S_WA: begin
        if (sq_done) begin
          sq_start  = 1'b1;
          sq_x      = nb_r;
          state_nxt = csim_pkg::S_WB;
        end
      end
      csim_pkg::S_WB: begin
        if (sq_done) begin
          if (ra_r == '0 || sq_root == '0) state_nxt = csim_pkg::S_OUT;
          else                              state_nxt = csim_pkg::S_MULD;
        end
      end
      csim_pkg::S_MULD: state_nxt = csim_pkg::S_CHK;
      csim_pkg::S_CHK: begin
        if (sat) begin
          state_nxt = csim_pkg::S_OUT;
        end else begin
          dv_start  = 1'b1;
          state_nxt = csim_pkg::S_WD;
        end
      end
      csim_pkg::S_WD: if (dv_done) state_nxt = csim_pkg::S_OUT;
      csim_pkg::S_OUT: if (out_free) state_nxt = csim_pkg::S_IDLE;
      default: state_nxt = csim_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= csim_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Control state: accumulators, count, overflow flag and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r       <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      cnt_r       <= '0;
      too_long_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A result taken in the same cycle as a new one is loaded stays valid.
      if (out_valid_r && out_ch.ready && !(state_r == csim_pkg::S_OUT))
        out_valid_r <= 1'b0;
      case (state_r)
        csim_pkg::S_IDLE: if (accept && drop) too_long_r <= 1'b1;
        csim_pkg::S_MAA:  dot_r <= dot_r + prod[ACC_W-1:0];
        csim_pkg::S_MBB:  na_r  <= na_r + prod[ACC_W-1:0];
        csim_pkg::S_ACC: begin
          nb_r  <= nb_r + prod[ACC_W-1:0];
          cnt_r <= cnt_r + 1'b1;
        end
        csim_pkg::S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            dot_r       <= '0;
            na_r        <= '0;
            nb_r        <= '0;
            cnt_r       <= '0;
            too_long_r  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the item in flight and of the pending result.
  always_ff @(posedge clk) begin
    case (state_r)
      csim_pkg::S_IDLE: begin
        if (accept) begin
          a_r        <= in_ch.elem_a;
          b_r        <= in_ch.elem_b;
          last_r     <= in_ch.last;
          pend_sim_r <= '0;
          pend_z_r   <= 1'b0;
          pend_o_r   <= 1'b1;
        end
      end
      csim_pkg::S_SQA: begin
        pend_o_r <= 1'b0;
        mag_r    <= dot_mag;
        neg_r    <= dot_r[ACC_W-1];
      end
      csim_pkg::S_WA: if (sq_done) ra_r <= sq_root;
      csim_pkg::S_WB: begin
        if (sq_done) pend_z_r <= (ra_r == '0 || sq_root == '0);
      end
      csim_pkg::S_CHK: if (sat) pend_sim_r <= sat_sim;
      csim_pkg::S_WD:  if (dv_done) pend_sim_r <= div_sim;
      csim_pkg::S_OUT: begin
        if (out_free) begin
          out_sim_r <= pend_sim_r;
          out_z_r   <= pend_z_r;
          out_o_r   <= pend_o_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.similarity = out_sim_r;
  assign out_ch.zero_norm  = out_z_r;
  assign out_ch.overflow   = out_o_r;

  csim_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  csim_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  csim_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dv_start),
    .rem0    ({2'b00, mag_r[ACC_W-1:2]}),
    .lo      (mag_r[1:0]),
    .divisor (divisor),
    .done    (dv_done),
    .quot    (dv_quot)
  );

  `CSIM_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(MAX_LEN), "pair count beyond MAX_LEN")
  `CSIM_NEVER(a_flags_excl, clk, rst_n, out_valid_r && out_z_r && out_o_r, "both flags set")
  `CSIM_ASSERT(a_flag_zero, clk, rst_n, (out_valid_r && (out_z_r || out_o_r)) |-> out_sim_r == '0, "flagged result not zero")
  `CSIM_ASSERT(a_sqrt_wait, clk, rst_n, sq_done |-> (state_r == csim_pkg::S_WA || state_r == csim_pkg::S_WB), "root done outside wait")

endmodule
